/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/imt_pkg.sv */
// ----------------------------------------------------------------------------
// imt_pkg
// Types and constants of the interval map table.
// ----------------------------------------------------------------------------
package imt_pkg;

  localparam int KEY_BITS          = 16;
  localparam int VALUE_BITS        = 8;
  localparam int TABLE_DEPTH_DEF   = 32;
  localparam int ENTRY_COUNT_BITS  = 6;
  localparam int STATUS_BITS       = 2;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                  command;
    logic [KEY_BITS-1:0]   key_begin;
    logic [KEY_BITS-1:0]   key_end;
    logic [VALUE_BITS-1:0] new_value;
  } in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]       read_value;
    logic [STATUS_BITS-1:0]      status;
    logic [ENTRY_COUNT_BITS-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] val;
  } entry_t;

endpackage

/* rtl/core/interval_map_table_core.sv */
// A lookup or empty assign scans the N entries held; an assign also inserts its two
//   boundaries during the scan, then copies the C entries of the new table back
//   when they fit (C <= TABLE_DEPTH).
// Throughput: one transaction at a time; the scan reads each entry through the table's
//   registered read port in S_WAIT and S_SCAN; the copy moves one entry a cycle.
// Reset (rst, synchronous): table empty, default value 0, no result pending.
// ----------------------------------------------------------------------------
// interval_map_table_core
// Sorted boundary table with range assign and lookup, one scan per command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module interval_map_table_core #(
  parameter int TABLE_DEPTH = imt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [imt_pkg::VALUE_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  imt_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output imt_pkg::out_t                 out_data
);
  import imt_pkg::*;

  localparam int SD  = TABLE_DEPTH + 2;
  localparam int TIW = $clog2(TABLE_DEPTH);
  localparam int UW  = $clog2(TABLE_DEPTH + 1);
  localparam int SIW = $clog2(SD);
  localparam int CW  = $clog2(SD + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WAIT = 5'b00010,
    S_SCAN = 5'b00100,
    S_COPY = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state;

  entry_t table_mem [TABLE_DEPTH];
  entry_t scratch   [SD];
  entry_t rd_ent;
  entry_t scr_q;

  logic [VALUE_BITS-1:0]  default_value;
  logic [UW-1:0]          used;
  logic [UW-1:0]          i;
  logic [CW-1:0]          c;
  logic [CW-1:0]          j;
  logic [CW-1:0]          cp_j;
  logic                   cp_v;
  in_t                    cur;
  logic                   is_assign;
  logic                   kb_done;
  logic                   ke_done;
  logic [VALUE_BITS-1:0]  prev;
  logic [VALUE_BITS-1:0]  endv;
  logic [VALUE_BITS-1:0]  lookv;
  logic [STATUS_BITS-1:0] status_r;
  logic                   assigned;

  logic                  at_end;
  logic                  take_kb;
  logic                  take_ke;
  logic                  take_ent;
  logic                  emit_on;
  logic                  scr_we;
  entry_t                emit_e;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    at_end   = (i == used);
    take_kb  = !kb_done && (at_end || rd_ent.key >= cur.key_begin);
    take_ke  = !take_kb && !ke_done && (at_end || rd_ent.key > cur.key_end);
    take_ent = !take_kb && !take_ke && !at_end;
    emit_e   = rd_ent;
    if (take_kb) begin
      emit_e = '{key: cur.key_begin, val: cur.new_value};
    end else if (take_ke) begin
      emit_e = '{key: cur.key_end, val: endv};
    end
    emit_on = (state == S_SCAN) && (take_kb || take_ke ||
              (take_ent && is_assign &&
               (rd_ent.key < cur.key_begin || rd_ent.key > cur.key_end)));
    // drop entries that repeat the value in force before them
    scr_we  = emit_on && (emit_e.val != prev);
  end

  always_ff @(posedge clk) begin
    rd_ent <= table_mem[i[TIW-1:0]];
    if (cp_v) begin
      table_mem[cp_j[TIW-1:0]] <= scr_q;
    end
  end

  always_ff @(posedge clk) begin
    scr_q <= scratch[j[SIW-1:0]];
    if (scr_we) begin
      scratch[c[SIW-1:0]] <= emit_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      default_value <= '0;
      used          <= '0;
      out_valid     <= 1'b0;
      cp_v          <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_value <= cfg_wdata;
      end
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      cp_v <= (state == S_COPY) && (j < c);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur       <= in_data;
            i         <= '0;
            c         <= '0;
            prev      <= default_value;
            endv      <= default_value;
            lookv     <= default_value;
            assigned  <= 1'b0;
            is_assign <= (in_data.command == CMD_ASSIGN) &&
                         (in_data.key_begin < in_data.key_end);
            kb_done   <= !((in_data.command == CMD_ASSIGN) &&
                           (in_data.key_begin < in_data.key_end));
            ke_done   <= !((in_data.command == CMD_ASSIGN) &&
                           (in_data.key_begin < in_data.key_end));
            status_r  <= ((in_data.command == CMD_ASSIGN) &&
                          (in_data.key_begin >= in_data.key_end)) ? ST_EMPTY : ST_DONE;
            state     <= S_WAIT;
          end
        end
        S_WAIT: state <= S_SCAN;
        S_SCAN: begin
          if (scr_we) begin
            c    <= c + 1'b1;
            prev <= emit_e.val;
          end
          if (take_kb) begin
            kb_done <= 1'b1;
          end else if (take_ke) begin
            ke_done <= 1'b1;
          end else if (take_ent) begin
            if (rd_ent.key <= cur.key_end) begin
              endv <= rd_ent.val;
            end
            if (rd_ent.key <= cur.key_begin) begin
              lookv <= rd_ent.val;
            end
            i     <= i + 1'b1;
            state <= S_WAIT;
          end else if (!is_assign) begin
            state <= S_RESP;
          end else if (c > CW'(TABLE_DEPTH)) begin
            status_r <= ST_FULL;
            state    <= S_RESP;
          end else begin
            j     <= '0;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          if (j < c) begin
            cp_j <= j;
            j    <= j + 1'b1;
          end else begin
            used     <= UW'(c);
            assigned <= 1'b1;
            state    <= S_RESP;
          end
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.read_value  <= assigned ? cur.new_value : lookv;
            out_data.status      <= status_r;
            out_data.entry_count <= ENTRY_COUNT_BITS'(used);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_used_bound, clk, rst, used <= UW'(TABLE_DEPTH))
  `ASSERT_ALWAYS(a_scratch_bound, clk, rst, c <= CW'(SD))
  `ASSERT_IMPLY(a_copy_write, clk, rst, cp_v, state == S_COPY || state == S_RESP)
  `ASSERT_IMPLY(a_out_from_resp, clk, rst, $rose(out_valid), $past(state == S_RESP))

endmodule
